/* hw/rtl/nsfc_pkg.sv */
// ----------------------------------------------------------------------------
// nsfc_pkg
// shared types and constants of the note schedule format checker
// ----------------------------------------------------------------------------
package nsfc_pkg;

	localparam int KEY_COUNT    = 88;
	localparam int VOICE_LIMIT  = 10;
	localparam int HEADER_BYTES = 16;
	localparam int RECORD_BYTES = 12;
	localparam int KEY_W        = $clog2(KEY_COUNT);
	localparam int VC_W         = $clog2(VOICE_LIMIT + 1);
	localparam int VI_W         = (VOICE_LIMIT > 1) ? $clog2(VOICE_LIMIT) : 1;

	localparam logic [20:0] POS_MAX       = 21'h1FFFFF;
	localparam logic [20:0] MAX_BYTES_RST = 21'd65536;
	localparam logic [15:0] MIN_GAP_RST   = 16'd100;

	localparam logic [7:0] MAGIC0 = 8'h53;
	localparam logic [7:0] MAGIC1 = 8'h50;
	localparam logic [7:0] MAGIC2 = 8'h50;
	localparam logic [7:0] MAGIC3 = 8'h31;

	localparam logic CFG_MAX_BYTES = 1'b0;
	localparam logic CFG_MIN_GAP   = 1'b1;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_SIZE     = 3'd1;
	localparam logic [2:0] ERR_FORMAT   = 3'd2;
	localparam logic [2:0] ERR_COUNT    = 3'd3;
	localparam logic [2:0] ERR_NOTE     = 3'd4;
	localparam logic [2:0] ERR_UNSORTED = 3'd5;
	localparam logic [2:0] ERR_POLY     = 3'd6;

	// word from front to back: a full record, the end-of-artifact verdict, or both
	typedef struct packed {
		logic        is_last;
		logic        has_rec;
		logic [31:0] rec_start;
		logic [31:0] rec_dur;
		logic [7:0]  rec_key;
		logic [7:0]  rec_lead;
		logic [7:0]  version;
		logic [2:0]  pre_err;
		logic [31:0] count;
		logic [31:0] duration;
	} work_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  error_code;
		logic [16:0] note_total;
		logic [31:0] total_ms;
	} res_t;

endpackage

/* hw/rtl/nsfc_if.sv */
// ----------------------------------------------------------------------------
// nsfc_in_if / nsfc_out_if
// valid/ready channels of the checker
// ----------------------------------------------------------------------------
interface nsfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nsfc_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  error_code;
	logic [16:0] note_total;
	logic [31:0] total_ms;
	modport source (output valid, output accepted, output error_code, output note_total,
		output total_ms, input ready);
	modport sink   (input valid, input accepted, input error_code, input note_total,
		input total_ms, output ready);
endinterface

/* hw/rtl/nsfc_front.sv */
// ----------------------------------------------------------------------------
// nsfc_front
// byte parser: header checks, record assembly, size, format and count verdict
// ----------------------------------------------------------------------------
module nsfc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [20:0]        max_bytes,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               wv,
	input  logic               wr,
	output nsfc_pkg::work_t    wd
);

	logic [20:0] pos_q;
	logic        over_q;
	logic        hdr_ok_q;
	logic [7:0]  ver_q;
	logic [31:0] cnt_q, dur_q, rs_q, rd_q;
	logic [7:0]  rk_q, rl_q, off_q;
	logic        go;
	logic        hdr;
	logic [20:0] p;
	logic [31:0] ns, nd;
	logic [7:0]  nk, nl;
	logic        rec_end;
	logic [20:0] npos;
	logic        nover;
	logic [31:0] nc, ndur;
	logic        nhok;
	logic [7:0]  nver;
	logic [2:0]  perr;
	logic [53:0] exp_size;

	function automatic logic [31:0] put_b(logic [31:0] w, logic [1:0] i, logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[i*8 +: 8] = b;
		return r;
	endfunction

	assign in_ready = !wv || wr;
	assign go       = in_valid && in_ready;
	assign hdr      = !over_q && (pos_q < 21'(nsfc_pkg::HEADER_BYTES));
	assign p        = pos_q;

	always_comb begin
		nhok = hdr_ok_q;
		nver = ver_q;
		nc   = cnt_q;
		ndur = dur_q;
		ns   = rs_q;
		nd   = rd_q;
		nk   = rk_q;
		nl   = rl_q;
		rec_end = 1'b0;
		if (hdr) begin
			case (p)
				21'd0: if (data_byte != nsfc_pkg::MAGIC0) nhok = 1'b0;
				21'd1: if (data_byte != nsfc_pkg::MAGIC1) nhok = 1'b0;
				21'd2: if (data_byte != nsfc_pkg::MAGIC2) nhok = 1'b0;
				21'd3: if (data_byte != nsfc_pkg::MAGIC3) nhok = 1'b0;
				21'd4: nver = data_byte;
				21'd6: if (data_byte != 8'(nsfc_pkg::RECORD_BYTES)) nhok = 1'b0;
				21'd7: if (data_byte != 8'd0) nhok = 1'b0;
				default: begin
					if (p >= 21'd8 && p < 21'd12) nc = put_b(cnt_q, p[1:0], data_byte);
					else if (p >= 21'd12 && p < 21'd16) ndur = put_b(dur_q, p[1:0], data_byte);
				end
			endcase
		end else begin
			if (off_q < 8'd4) ns = put_b(rs_q, off_q[1:0], data_byte);
			else if (off_q < 8'd8) nd = put_b(rd_q, off_q[1:0], data_byte);
			else if (off_q == 8'd8) nk = data_byte;
			else if (off_q == 8'd11) nl = data_byte;
			rec_end = off_q >= 8'(nsfc_pkg::RECORD_BYTES - 1);
		end
		nover = over_q || (pos_q >= nsfc_pkg::POS_MAX);
		npos  = (pos_q >= nsfc_pkg::POS_MAX) ? pos_q : pos_q + 21'd1;
		exp_size = 54'(nsfc_pkg::HEADER_BYTES) + 54'(nc) * 54'(nsfc_pkg::RECORD_BYTES);
		if (nover || npos < 21'(nsfc_pkg::HEADER_BYTES) || npos > max_bytes)
			perr = nsfc_pkg::ERR_SIZE;
		else if (!nhok || (nver != 8'd1 && nver != 8'd2))
			perr = nsfc_pkg::ERR_FORMAT;
		else if (nc == 32'd0 || exp_size != 54'(npos))
			perr = nsfc_pkg::ERR_COUNT;
		else
			perr = nsfc_pkg::ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; over_q <= 1'b0; hdr_ok_q <= 1'b1; ver_q <= '0;
			cnt_q <= '0; dur_q <= '0; rs_q <= '0; rd_q <= '0;
			rk_q <= '0; rl_q <= '0; off_q <= '0; wv <= 1'b0; wd <= '0;
		end else begin
			if (wr) wv <= 1'b0;
			if (go) begin
				wv         <= rec_end || last_byte;
				wd.is_last   <= last_byte;
				wd.has_rec   <= rec_end;
				wd.rec_start <= ns;
				wd.rec_dur   <= nd;
				wd.rec_key   <= nk;
				wd.rec_lead  <= nl;
				wd.version   <= nver;
				wd.pre_err   <= perr;
				wd.count     <= nc;
				wd.duration  <= ndur;
				if (last_byte) begin
					pos_q <= '0; over_q <= 1'b0; hdr_ok_q <= 1'b1; ver_q <= '0;
					cnt_q <= '0; dur_q <= '0; rs_q <= '0; rd_q <= '0;
					rk_q <= '0; rl_q <= '0; off_q <= '0;
				end else begin
					pos_q <= npos; over_q <= nover; hdr_ok_q <= nhok; ver_q <= nver;
					cnt_q <= nc; dur_q <= ndur; rs_q <= ns; rd_q <= nd;
					rk_q <= nk; rl_q <= nl;
					if (!hdr) off_q <= rec_end ? 8'd0 : off_q + 8'd1;
				end
			end
		end
	end

endmodule

/* hw/rtl/nsfc_fifo.sv */
// ----------------------------------------------------------------------------
// nsfc_fifo
// two-entry queue between parser and note checker
// ----------------------------------------------------------------------------
module nsfc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            iv,
	output logic            ir,
	input  nsfc_pkg::work_t id,
	output logic            ov,
	input  logic            orr,
	output nsfc_pkg::work_t od
);

	nsfc_pkg::work_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign ir   = cnt_q != 2'd2;
	assign ov   = cnt_q != 2'd0;
	assign od   = mem_q[rp_q];
	assign push = iv && ir;
	assign pop  = ov && orr;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTH
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("fifo count lost");
	a_cnt_rng: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("fifo overfilled");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> !ov) else $error("fifo shows data when empty");
`endif

endmodule

/* hw/rtl/nsfc_back.sv */
// ----------------------------------------------------------------------------
// nsfc_back
// note checker: key gaps, sort order, voices, largest end, verdict
// ----------------------------------------------------------------------------
module nsfc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     min_gap_ms,
	input  logic            wv,
	output logic            wr,
	input  nsfc_pkg::work_t wd,
	output logic            ov,
	input  logic            orr,
	output nsfc_pkg::res_t  od
);

	typedef enum logic [1:0] {S_IDLE, S_KEY, S_SWEEP, S_COMMIT} state_t;
	state_t state_q;

	logic [31:0] key_mem [nsfc_pkg::KEY_COUNT];
	logic [nsfc_pkg::KEY_COUNT-1:0] used_q;
	logic [31:0] ve_q [nsfc_pkg::VOICE_LIMIT];
	logic [nsfc_pkg::VC_W-1:0] vc_q, n_q;
	logic [nsfc_pkg::VC_W-1:0] i_q;
	logic [31:0] prev_q, large_q, ke_q, act_q, end_q;
	logic [2:0]  fne_q;
	logic        kused_q;
	logic        done_q;
	logic [nsfc_pkg::KEY_W-1:0] key_q;
	logic [31:0] lead, act;
	logic [32:0] wide;
	logic        bad0;
	logic [2:0]  err;
	logic [nsfc_pkg::KEY_W-1:0] kidx;

	assign lead = (wd.version >= 8'd2) ? {24'd0, wd.rec_lead} : 32'd0;
	assign act  = wd.rec_start - lead;
	assign wide = {1'b0, wd.rec_start} + {1'b0, wd.rec_dur};
	assign kidx = wd.rec_key[nsfc_pkg::KEY_W-1:0];
	assign bad0 = wd.rec_dur == 32'd0 || wd.rec_key >= 8'(nsfc_pkg::KEY_COUNT) ||
		lead > wd.rec_start || (wd.version == 8'd1 && wd.rec_lead != 8'd0) || wide[32];
	assign wr = (state_q == S_IDLE) && wv && (!wd.is_last || !ov || orr) &&
		!(wd.has_rec && fne_q == nsfc_pkg::ERR_NONE && !bad0 && !done_q);

	always_comb begin
		if (wd.pre_err != nsfc_pkg::ERR_NONE) err = wd.pre_err;
		else if (fne_q != nsfc_pkg::ERR_NONE) err = fne_q;
		else if (wd.has_rec && bad0) err = nsfc_pkg::ERR_NOTE;
		else if (wd.duration != large_q) err = nsfc_pkg::ERR_NOTE;
		else err = nsfc_pkg::ERR_NONE;
	end

	always_ff @(posedge clk) begin
		ke_q <= key_mem[kidx];
		if (state_q == S_COMMIT && n_q < nsfc_pkg::VC_W'(nsfc_pkg::VOICE_LIMIT))
			key_mem[key_q] <= end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; used_q <= '0; vc_q <= '0; n_q <= '0; i_q <= '0;
			prev_q <= '0; large_q <= '0; fne_q <= nsfc_pkg::ERR_NONE; ov <= 1'b0;
			kused_q <= 1'b0; key_q <= '0; act_q <= '0; end_q <= '0; done_q <= 1'b0;
			od <= '0;
		end else begin
			if (ov && orr) ov <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (wv && wd.has_rec && fne_q == nsfc_pkg::ERR_NONE && !done_q) begin
						if (bad0) fne_q <= nsfc_pkg::ERR_NOTE;
						else begin
							key_q   <= kidx;
							kused_q <= used_q[kidx];
							act_q   <= act;
							end_q   <= wide[31:0];
							state_q <= S_KEY;
						end
					end
					if (wr) done_q <= 1'b0;
					if (wr && wd.is_last) begin
						ov            <= 1'b1;
						od.accepted   <= err == nsfc_pkg::ERR_NONE;
						od.error_code <= err;
						od.note_total <= (err == nsfc_pkg::ERR_NONE) ? wd.count[16:0] : 17'd0;
						od.total_ms   <= (err == nsfc_pkg::ERR_NONE) ? wd.duration : 32'd0;
						used_q <= '0; vc_q <= '0; prev_q <= '0; large_q <= '0;
						fne_q <= nsfc_pkg::ERR_NONE;
					end
				end
				S_KEY: begin
					if (kused_q && (ke_q > act_q || (act_q - ke_q) < {16'd0, min_gap_ms})) begin
						fne_q <= nsfc_pkg::ERR_NOTE; state_q <= S_IDLE; done_q <= 1'b1;
					end else if (act_q < prev_q) begin
						fne_q <= nsfc_pkg::ERR_UNSORTED; state_q <= S_IDLE; done_q <= 1'b1;
					end else begin
						prev_q <= act_q; i_q <= '0; n_q <= '0; state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (i_q < vc_q) begin
						if (ve_q[i_q[nsfc_pkg::VI_W-1:0]] > act_q) begin
							ve_q[n_q[nsfc_pkg::VI_W-1:0]] <= ve_q[i_q[nsfc_pkg::VI_W-1:0]];
							n_q <= n_q + 1'b1;
						end
						i_q <= i_q + 1'b1;
					end else state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					vc_q <= n_q;
					if (n_q >= nsfc_pkg::VC_W'(nsfc_pkg::VOICE_LIMIT))
						fne_q <= nsfc_pkg::ERR_POLY;
					else begin
						ve_q[n_q[nsfc_pkg::VI_W-1:0]] <= end_q;
						vc_q <= n_q + 1'b1;
						used_q[key_q] <= 1'b1;
						if (end_q > large_q) large_q <= end_q;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_vc: assert property (@(posedge clk) disable iff (!arst_n)
		vc_q <= nsfc_pkg::VC_W'(nsfc_pkg::VOICE_LIMIT)) else $error("voice count too big");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !wr) else $error("word taken while busy");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		(ov && !orr) |=> ov && $stable(od)) else $error("result dropped");
`endif

endmodule

/* hw/rtl/note_schedule_format_checker.sv */
// ----------------------------------------------------------------------------
// note_schedule_format_checker
// streaming header and note record checker with one verdict per artifact
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   data_byte, last_byte
// out_ch    out  accepted, error_code, note_total, total_ms
// cfg       in   cfg_we, cfg_index, cfg_data
//
// one byte per cycle into the parser while it is not back-pressured; each record's
// last byte sends the note checker through start, key check, voice sweep, commit
// and hand-off, which back-pressures the byte stream through the two-word queue.
// arst_n clears all control state; stalls on the result side hold the verdict.
// ----------------------------------------------------------------------------
module note_schedule_format_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [20:0]  cfg_data,
	nsfc_in_if.sink      in_ch,
	nsfc_out_if.source   out_ch
);

	logic [20:0] max_bytes_q;
	logic [15:0] min_gap_q;
	logic fv, fr, bv, br;
	nsfc_pkg::work_t fd, bd;
	nsfc_pkg::res_t  rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= nsfc_pkg::MAX_BYTES_RST;
			min_gap_q   <= nsfc_pkg::MIN_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nsfc_pkg::CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				nsfc_pkg::CFG_MIN_GAP:   min_gap_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	nsfc_front u_front (.clk, .arst_n, .max_bytes(max_bytes_q), .in_valid(in_ch.valid),
		.in_ready(in_ch.ready), .data_byte(in_ch.data_byte), .last_byte(in_ch.last_byte),
		.wv(fv), .wr(fr), .wd(fd));

	nsfc_fifo u_fifo (.clk, .arst_n, .iv(fv), .ir(fr), .id(fd), .ov(bv), .orr(br), .od(bd));

	nsfc_back u_back (.clk, .arst_n, .min_gap_ms(min_gap_q), .wv(bv), .wr(br), .wd(bd),
		.ov(out_ch.valid), .orr(out_ch.ready), .od(rd));

	assign out_ch.accepted   = rd.accepted;
	assign out_ch.error_code = rd.error_code;
	assign out_ch.note_total = rd.note_total;
	assign out_ch.total_ms   = rd.total_ms;

endmodule

/* bench/nsfc_checker.sv */
// ----------------------------------------------------------------------------
// nsfc_checker
// watches the byte and verdict channels of the note schedule format checker,
// predicts each artifact verdict from the accepted bytes and compares it
// ----------------------------------------------------------------------------
module nsfc_checker
	import nsfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [20:0] cfg_data,
	nsfc_in_if          in_ch,
	nsfc_out_if         out_ch,
	output int          fails,
	output int          pending
);

	logic [20:0] size_limit;
	logic [15:0] key_gap;

	logic [20:0] pos;
	logic        pos_over;
	logic        hdr_ok;
	logic [7:0]  version;
	logic [31:0] decl_count;
	logic [31:0] decl_dur;
	logic [31:0] note_start;
	logic [31:0] note_dur;
	logic [7:0]  note_key;
	logic [7:0]  note_lead;
	logic [7:0]  rec_off;
	logic [31:0] voice_end [VOICE_LIMIT];
	int          voices;
	logic [31:0] key_end [KEY_COUNT];
	logic        key_busy [KEY_COUNT];
	logic [31:0] last_act;
	logic [31:0] latest_end;
	logic [2:0]  note_err;

	res_t verdicts [$];
	int   compared;

	assign pending = verdicts.size();

	task automatic clear_artifact();
		pos = '0;
		pos_over = 1'b0;
		hdr_ok = 1'b1;
		version = '0;
		decl_count = '0;
		decl_dur = '0;
		note_start = '0;
		note_dur = '0;
		note_key = '0;
		note_lead = '0;
		rec_off = '0;
		voices = 0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			key_busy[i] = 1'b0;
			key_end[i] = '0;
		end
		for (int i = 0; i < VOICE_LIMIT; i++)
			voice_end[i] = '0;
		last_act = '0;
		latest_end = '0;
		note_err = ERR_NONE;
	endtask

	task automatic check_note();
		logic [31:0] lead;
		logic [31:0] act;
		logic [32:0] sum;
		logic [31:0] ke;
		logic        bad;
		int          n;
		if (note_err != ERR_NONE)
			return;
		lead = (version >= 2) ? {24'd0, note_lead} : 32'd0;
		act = note_start - lead;
		sum = {1'b0, note_start} + {1'b0, note_dur};
		bad = note_dur == 0 || note_key >= KEY_COUNT || lead > note_start ||
			(version == 1 && note_lead != 0) || sum[32];
		if (!bad && key_busy[note_key]) begin
			ke = key_end[note_key];
			bad = ke > act || (act - ke) < {16'd0, key_gap};
		end
		if (bad) begin
			note_err = ERR_NOTE;
			return;
		end
		if (act < last_act) begin
			note_err = ERR_UNSORTED;
			return;
		end
		last_act = act;
		n = 0;
		for (int i = 0; i < voices && i < VOICE_LIMIT; i++)
			if (voice_end[i] > act) begin
				voice_end[n] = voice_end[i];
				n++;
			end
		voices = n;
		if (voices >= VOICE_LIMIT) begin
			note_err = ERR_POLY;
			return;
		end
		voice_end[voices] = sum[31:0];
		voices++;
		key_end[note_key] = sum[31:0];
		key_busy[note_key] = 1'b1;
		if (sum[31:0] > latest_end)
			latest_end = sum[31:0];
	endtask

	task automatic take_word(input logic [7:0] b, input logic lst);
		logic [2:0]       err;
		longint unsigned  want;
		res_t             r;
		if (!pos_over && pos < HEADER_BYTES) begin
			case (pos)
				0: if (b != MAGIC0) hdr_ok = 1'b0;
				1: if (b != MAGIC1) hdr_ok = 1'b0;
				2: if (b != MAGIC2) hdr_ok = 1'b0;
				3: if (b != MAGIC3) hdr_ok = 1'b0;
				4: version = b;
				6: if (b != RECORD_BYTES) hdr_ok = 1'b0;
				7: if (b != 0) hdr_ok = 1'b0;
				8, 9, 10, 11: decl_count[(pos - 8) * 8 +: 8] = b;
				12, 13, 14, 15: decl_dur[(pos - 12) * 8 +: 8] = b;
				default: ;
			endcase
		end else begin
			if (rec_off < 4) note_start[rec_off * 8 +: 8] = b;
			else if (rec_off < 8) note_dur[(rec_off - 4) * 8 +: 8] = b;
			else if (rec_off == 8) note_key = b;
			else if (rec_off == 11) note_lead = b;
			if (rec_off >= RECORD_BYTES - 1) begin
				check_note();
				rec_off = '0;
			end else
				rec_off++;
		end
		if (pos >= POS_MAX) pos_over = 1'b1;
		else pos++;
		if (!lst)
			return;
		want = 64'd16 + 64'd12 * decl_count;
		if (pos_over || pos < HEADER_BYTES || pos > size_limit)
			err = ERR_SIZE;
		else if (!hdr_ok || (version != 1 && version != 2))
			err = ERR_FORMAT;
		else if (decl_count == 0 || want != pos)
			err = ERR_COUNT;
		else if (note_err != ERR_NONE)
			err = note_err;
		else if (decl_dur != latest_end)
			err = ERR_NOTE;
		else
			err = ERR_NONE;
		r.accepted = (err == ERR_NONE);
		r.error_code = err;
		r.note_total = (err == ERR_NONE) ? decl_count[16:0] : 17'd0;
		r.total_ms = (err == ERR_NONE) ? decl_dur : 32'd0;
		verdicts.push_back(r);
		clear_artifact();
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("verdict %0d: %s got %0d want %0d", compared, what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		compared = 0;
		size_limit = MAX_BYTES_RST;
		key_gap = MIN_GAP_RST;
		clear_artifact();
	end

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			size_limit = MAX_BYTES_RST;
			key_gap = MIN_GAP_RST;
			clear_artifact();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_BYTES) size_limit = cfg_data;
				else key_gap = cfg_data[15:0];
			end
			if (in_ch.valid && in_ch.ready)
				take_word(in_ch.data_byte, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (verdicts.size() == 0) begin
					$display("verdict %0d: unexpected word", compared);
					fails++;
				end else begin
					e = verdicts.pop_front();
					if (out_ch.accepted !== e.accepted)
						report("accepted", out_ch.accepted, e.accepted);
					if (out_ch.error_code !== e.error_code)
						report("error_code", out_ch.error_code, e.error_code);
					if (out_ch.note_total !== e.note_total)
						report("note_total", out_ch.note_total, e.note_total);
					if (out_ch.total_ms !== e.total_ms)
						report("total_ms", out_ch.total_ms, e.total_ms);
				end
				compared++;
			end
		end
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives byte streams of note schedules, well formed and damaged, through the
// checker under several register settings and flow control patterns; a side
// checker predicts every verdict and counts mismatches
// ----------------------------------------------------------------------------
module testbench;
	import nsfc_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [20:0] cfg_data;
	int          fails;
	int          pending;
	int          words_sent;
	int          artifacts;
	int          idle_cycles = 0;
	int          send_idle;
	int          recv_stall;
	logic [7:0]  art [$];
	logic [31:0] gap_now;

	nsfc_in_if  in_ch ();
	nsfc_out_if out_ch ();

	note_schedule_format_checker u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	nsfc_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("note_schedule_format_checker: mismatch");
			$finish;
		end
	end

	task automatic put32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			art.push_back(v[i * 8 +: 8]);
	endtask

	task automatic put_header(input logic [7:0] ver, input logic [31:0] cnt,
			input logic [31:0] dur);
		art.push_back(MAGIC0);
		art.push_back(MAGIC1);
		art.push_back(MAGIC2);
		art.push_back(MAGIC3);
		art.push_back(ver);
		art.push_back($urandom_range(0, 255));
		art.push_back(RECORD_BYTES);
		art.push_back(8'd0);
		put32(cnt);
		put32(dur);
	endtask

	task automatic put_note(input logic [31:0] start, input logic [31:0] dur,
			input logic [7:0] key, input logic [7:0] lead, input logic [7:0] fill);
		put32(start);
		put32(dur);
		art.push_back(key);
		art.push_back(fill);
		art.push_back(~fill);
		art.push_back(lead);
	endtask

	task automatic send_art();
		for (int i = 0; i < art.size(); i++) begin
			in_ch.valid <= 1'b1;
			in_ch.data_byte <= art[i];
			in_ch.last_byte <= (i == art.size() - 1);
			do @(posedge clk); while (!in_ch.ready);
			words_sent++;
			if ($urandom_range(0, 99) < send_idle) begin
				in_ch.valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
			end
		end
		artifacts++;
		art.delete();
	endtask

	// mostly well formed schedule, sometimes damaged afterwards or plain random bytes
	task automatic make_art();
		logic [31:0] t, lead, start, dur, top_end;
		logic [31:0] kend [KEY_COUNT];
		logic        kuse [KEY_COUNT];
		logic [7:0]  ver, key;
		int          n, wide_keys, k, pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			n = $urandom_range(1, 40);
			for (int i = 0; i < n; i++)
				art.push_back($urandom_range(0, 255));
			return;
		end
		for (int i = 0; i < KEY_COUNT; i++)
			kuse[i] = 1'b0;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
		ver = $urandom_range(1, 2);
		wide_keys = $urandom_range(0, 1);
		t = ($urandom_range(0, 19) == 0) ? 32'hFFFF_F000 : $urandom_range(0, 300);
		top_end = '0;
		put_header(ver, n, 0);
		for (int i = 0; i < n; i++) begin
			t = t + $urandom_range(0, 60);
			key = wide_keys ? $urandom_range(0, KEY_COUNT - 1) : $urandom_range(0, 7);
			if (kuse[key] && kend[key] + gap_now > t && $urandom_range(0, 9) != 0)
				t = kend[key] + gap_now;
			lead = (ver == 2) ? $urandom_range(0, 40) : 0;
			if (lead > 32'hFFFF_FFFF - t) lead = 0;
			start = t + lead;
			dur = $urandom_range(1, 400);
			put_note(start, dur, key, lead[7:0], $urandom_range(0, 1) ? 8'hFF : 8'h00);
			kuse[key] = 1'b1;
			kend[key] = start + dur;
			if (start + dur > top_end) top_end = start + dur;
		end
		for (int i = 0; i < 4; i++)
			art[12 + i] = top_end[i * 8 +: 8];
		if (pick < 40) begin
			case ($urandom_range(0, 3))
				0: art[$urandom_range(0, art.size() - 1)] = $urandom_range(0, 255);
				1: begin
					k = $urandom_range(1, 12);
					for (int i = 0; i < k && art.size() > 1; i++)
						void'(art.pop_back());
				end
				2: begin
					k = $urandom_range(1, 12);
					for (int i = 0; i < k; i++)
						art.push_back($urandom_range(0, 255));
				end
				default: art[12] = art[12] ^ (8'd1 << $urandom_range(0, 7));
			endcase
		end
	endtask

	task automatic write_reg(input logic idx, input logic [20:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_GAP) gap_now = val[15:0];
		@(posedge clk);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		logic [20:0] size_set [8];
		logic [20:0] gap_set [8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_BYTES;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		words_sent = 0;
		artifacts = 0;
		send_idle = 0;
		recv_stall = 0;
		gap_now = MIN_GAP_RST;
		size_set = '{21'd65536, 21'd1048576, 21'd16, 21'd120, 21'd65536, 21'd1048576,
			21'd60, 21'd2000};
		gap_set = '{21'd100, 21'd0, 21'd65535, 21'd100, 21'd0, 21'd300, 21'd65535, 21'd37};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and the size, format, count, note and accept verdicts on short artifacts
		art.push_back(8'hFF);
		send_art();
		put_header(1, 0, 0);
		send_art();
		put_header(1, 1, 1);
		art[0] = 8'h00;
		put_note(0, 1, 0, 0, 8'h00);
		send_art();
		put_header(3, 1, 11);
		put_note(10, 1, 0, 0, 8'h00);
		send_art();
		put_header(1, 1, 32'hFFFF_FFFF);
		put_note(32'hFFFF_FFFE, 1, 87, 0, 8'hFF);
		send_art();
		put_header(2, 1, 300);
		put_note(200, 100, 88, 255, 8'h00);
		send_art();
		put_header(2, 1, 300);
		put_note(20, 0, 255, 40, 8'hFF);
		send_art();

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(CFG_MAX_BYTES, size_set[ph]);
			write_reg(CFG_MIN_GAP, gap_set[ph]);
			send_idle = (ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 30 : 0;
			recv_stall = (ph % 4 == 2) ? 71 : (ph % 4 == 3) ? 30 : 0;
			while (words_sent < 100 + (ph + 1) * 155) begin
				make_art();
				send_art();
			end
		end
		settle();
		$display("sent %0d bytes in %0d artifacts over 8 register and flow settings",
			words_sent, artifacts);
		if (fails == 0)
			$display("note_schedule_format_checker: match");
		else
			$display("note_schedule_format_checker: mismatch");
		$finish;
	end

endmodule
